FILE: hdl/tmcw_pkg.sv
package tmcw_pkg;

    // Field widths of the stream payloads.
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;

    // Packed stream widths: input is character, value, color; output is
    // write address, cell data, cursor position, padded to whole bytes.
    localparam int S_TDATA_W = CHAR_W + VALUE_W + COLOR_W;
    localparam int M_USED_W  = ADDR_W + CELL_W + ADDR_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Command codes carried in the input tuser bit.
    localparam logic CMD_PUT_CHAR = 1'b0;
    localparam logic CMD_PUT_HEX  = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30;
    localparam logic [CHAR_W-1:0] LETTER_BASE  = 8'h61;

    // A hex item prints eight nibbles.
    localparam int HEX_DIGITS = 8;
    localparam int DIGIT_W    = 3;
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = 3'd7;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    // One classified operation, as the front hands it to the back.
    typedef struct packed {
        logic                 is_hex;
        logic                 is_newline;
        logic [CHAR_W-1:0]    character;
        logic [VALUE_W-1:0]   value;
        logic [COLOR_W-1:0]   color;
    } t_op;

    // Queue status as the back sees it.
    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

    // Lowercase ASCII for one nibble.
    function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nibble);
        logic [CHAR_W-1:0] code;
        if (nibble <= 4'd9) begin
            code = DIGIT_BASE + {4'd0, nibble};
        end else begin
            code = LETTER_BASE + {4'd0, nibble} - 8'd10;
        end
        return code;
    endfunction

endpackage

FILE: hdl/tmcw_front.sv
module tmcw_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tmcw_pkg::S_TDATA_W-1:0] i_data,
    input  logic                          i_command,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output tmcw_pkg::t_op                 o_op
);

    // Field boundaries inside the input tdata.
    localparam int VAL_LO = tmcw_pkg::CHAR_W;
    localparam int COL_LO = tmcw_pkg::CHAR_W + tmcw_pkg::VALUE_W;

    logic [tmcw_pkg::CHAR_W-1:0] w_char;

    assign w_char = i_data[tmcw_pkg::CHAR_W-1:0];

    // A beat is taken whenever the queue has room.
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Classify the beat: hex print, newline, or plain cell write.
    always_comb begin
        o_op.is_hex     = (i_command == tmcw_pkg::CMD_PUT_HEX);
        o_op.is_newline = (i_command == tmcw_pkg::CMD_PUT_CHAR) &&
                          (w_char == tmcw_pkg::NEWLINE_CODE);
        o_op.character  = w_char;
        o_op.value      = i_data[VAL_LO +: tmcw_pkg::VALUE_W];
        o_op.color      = i_data[COL_LO +: tmcw_pkg::COLOR_W];
    end

endmodule

FILE: hdl/tmcw_queue.sv
module tmcw_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  tmcw_pkg::t_op           i_op,
    input  logic                    i_pop,
    output tmcw_pkg::t_op           o_op,
    output tmcw_pkg::t_queue_status o_status
);

    tmcw_pkg::t_op                r_mem [tmcw_pkg::Q_DEPTH];
    logic [tmcw_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [tmcw_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [tmcw_pkg::Q_CW-1:0]    r_count;

    assign o_op            = r_mem[r_rd_ptr];
    assign o_status.valid  = (r_count != '0);
    assign o_status.full   = (r_count == tmcw_pkg::Q_CW'(tmcw_pkg::Q_DEPTH));

    // Entry storage; written only on push.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tmcw_back.sv
module tmcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int COL_W   = 7,
    parameter int ROW_W   = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tmcw_pkg::t_queue_status        i_status,
    input  tmcw_pkg::t_op                  i_op,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tmcw_pkg::M_TDATA_W-1:0] o_data,
    output logic                           o_write_enable,
    output logic                           o_last
);

    localparam int AW = tmcw_pkg::ADDR_W;

    // Cursor state, with the linear cell index kept alongside.
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [AW-1:0]                r_idx, n_idx;
    logic [tmcw_pkg::DIGIT_W-1:0] r_digit;

    // Output register.
    logic                         r_out_valid;
    logic                         r_out_we;
    logic                         r_out_last;
    logic [AW-1:0]                r_out_addr;
    logic [tmcw_pkg::CELL_W-1:0]  r_out_cell;
    logic [AW-1:0]                r_out_cursor;

    logic                         w_load;
    logic                         w_final;
    logic                         w_col_end;
    logic                         w_row_end;
    logic [3:0]                   w_nibble;
    logic [tmcw_pkg::CHAR_W-1:0]  w_code;

    // One result per cycle whenever the queue holds an op and the output slot is free or draining.
    assign w_load  = i_status.valid && (!r_out_valid || i_ready);
    assign w_final = !i_op.is_hex || (r_digit == tmcw_pkg::LAST_DIGIT);
    assign o_pop   = w_load && w_final;

    // Current hex digit, most significant nibble first.
    assign w_nibble = i_op.value[{~r_digit, 2'b00} +: 4];
    assign w_code   = i_op.is_hex ? tmcw_pkg::hex_ascii(w_nibble) : i_op.character;

    assign w_col_end = (r_col == COL_W'(COLUMNS - 1));
    assign w_row_end = (r_row == ROW_W'(ROWS - 1));

    // Cursor advance. Moving to the next row adds COLUMNS - column to the
    // index; running off the last row returns everything to the top left.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_idx = r_idx;
        if (i_op.is_newline) begin
            n_col = '0;
            if (w_row_end) begin
                n_row = '0;
                n_idx = '0;
            end else begin
                n_row = r_row + 1'b1;
                n_idx = r_idx - AW'(r_col) + AW'(COLUMNS);
            end
        end else if (!w_col_end) begin
            n_col = r_col + 1'b1;
            n_idx = r_idx + 1'b1;
        end else begin
            n_col = '0;
            if (w_row_end) begin
                n_row = '0;
                n_idx = '0;
            end else begin
                n_row = r_row + 1'b1;
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // Cursor and digit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
            r_digit <= '0;
        end else if (w_load) begin
            r_col <= n_col;
            r_row <= n_row;
            r_idx <= n_idx;
            if (i_op.is_hex) begin
                r_digit <= r_digit + 1'b1;
            end
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; a newline carries zero address and cell.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_we     <= !i_op.is_newline;
            r_out_last   <= w_final;
            r_out_addr   <= i_op.is_newline ? '0 : r_idx;
            r_out_cell   <= i_op.is_newline ? '0 : {i_op.color, w_code};
            r_out_cursor <= n_idx;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_last         = r_out_last;
    assign o_data         = tmcw_pkg::M_TDATA_W'({r_out_cursor, r_out_cell, r_out_addr});

endmodule

FILE: hdl/text_mode_character_writer_core.sv
// Channel   | Direction | tdata (low bit up)                          | tuser        | tlast
// ----------+-----------+---------------------------------------------+--------------+------
// s_axis    | in        | character[7:0] value[39:8] color[47:40]     | command      | -
// m_axis    | out       | write_address[10:0] cell_data[26:11]        | write_enable | last
//           |           | cursor_position[37:27], zero pad [39:38]    |              |
//
// A character or newline beat yields one output beat; a hex beat yields eight.
// The back end issues one output beat per cycle while the output is not stalled, so
// characters stream at one per cycle and a hex beat occupies the back end until all eight digits are issued.
// An input beat passes through the queue and then the back end's output register before it appears on m_axis.
// A two-entry queue decouples input from output; input stalls only when it is full.
// Synchronous reset puts the cursor at the top-left cell and empties the queue.
module text_mode_character_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tmcw_pkg::S_TDATA_W-1:0] s_axis_tdata,  // character, value, color
    input  logic                           s_axis_tuser,  // command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tmcw_pkg::M_TDATA_W-1:0] m_axis_tdata,  // write_address, cell_data, cursor_position
    output logic                           m_axis_tuser,  // write_enable
    output logic                           m_axis_tlast
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                    w_push;
    logic                    w_pop;
    tmcw_pkg::t_op           w_in_op;
    tmcw_pkg::t_op           w_head_op;
    tmcw_pkg::t_queue_status w_status;

    // Front: take beats and classify them.
    tmcw_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_command    (s_axis_tuser),
        .i_queue_full (w_status.full),
        .o_push       (w_push),
        .o_op         (w_in_op)
    );

    // Queue between front and back.
    tmcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_in_op),
        .i_pop    (w_pop),
        .o_op     (w_head_op),
        .o_status (w_status)
    );

    // Back: cursor tracking and cell writes.
    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_status       (w_status),
        .i_op           (w_head_op),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata),
        .o_write_enable (m_axis_tuser),
        .o_last         (m_axis_tlast)
    );

endmodule

FILE: hdl/tmcw_checker.sv
module tmcw_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [tmcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tuser,
    input  logic                           m_axis_tlast
);

    localparam int AW = tmcw_pkg::ADDR_W;

    logic [AW-1:0]               w_addr;
    logic [tmcw_pkg::CELL_W-1:0] w_cell;
    logic [AW-1:0]               w_cursor;
    logic                        w_accept;
    logic [AW-1:0]               r_cursor;

    assign w_addr   = m_axis_tdata[AW-1:0];
    assign w_cell   = m_axis_tdata[AW +: tmcw_pkg::CELL_W];
    assign w_cursor = m_axis_tdata[AW + tmcw_pkg::CELL_W +: AW];
    assign w_accept = m_axis_tvalid && m_axis_tready;

    // Cursor as last reported on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (w_accept) begin
            r_cursor <= w_cursor;
        end
    end

    // A stalled beat stays valid and keeps its data and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // No output beat right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A newline beat writes nothing and ends its item.
    a_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast && (w_addr == '0) && (w_cell == '0))
        else $error("newline beat with address, data or no last");

    // Every cell is written where the cursor was left.
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> w_addr == r_cursor)
        else $error("cell written away from the cursor");

    // After a write the cursor moves one cell on or back to the top.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (w_cursor == w_addr + 1'b1) || (w_cursor == '0))
        else $error("cursor did not advance by one cell");

endmodule

bind text_mode_character_writer_core tmcw_checker u_tmcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
